// ===== rtl/core/tep_pkg.sv =====
// ============================================================================
// tep_pkg: shared types and constants for the timed event player
// Field widths, register indexes, time format limits and the time saturation
// helper used by the sequencer.
// ============================================================================
package tep_pkg;

    // Default table geometry
    localparam int FRAMES_DEF     = 256;
    localparam int NUM_VALUES_DEF = 4;
    localparam int OUT_VALUES     = 4;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int RATE_W    = 16;
    localparam int FRAME_W   = 8;
    localparam int CHAN_W    = 3;
    localparam int FIU_W     = 9;
    localparam int CFG_IDX_W = 4;

    // Play time is signed Q32.16
    localparam int TIME_W    = 48;
    localparam int RATE_FRAC = 8;

    localparam logic signed [TIME_W-1:0] LONG_FIRST = 48'sh00FF_FFFF_0000;
    localparam logic signed [TIME_W-1:0] TIME_MAX   = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [TIME_W-1:0] TIME_MIN   = 48'sh8000_0000_0000;

    // Register reset values
    localparam logic [FIU_W-1:0]  FRAMES_IN_USE_RST = 9'd256;
    localparam logic [DATA_W-1:0] TICK_DURATION_RST = 32'd87381;

    // Input item actions
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Table word channel holding the frame duration
    localparam logic [CHAN_W-1:0] CH_DURATION = 3'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_DURATION = 4'd1;

    // Clamp a one-bit-wider sum back into the signed time range
    function automatic logic signed [TIME_W-1:0] sat_time(input logic signed [TIME_W:0] v);
        logic signed [TIME_W-1:0] r;
        if (v[TIME_W] != v[TIME_W-1])
        begin
            r = v[TIME_W] ? TIME_MIN : TIME_MAX;
        end
        else
        begin
            r = v[TIME_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/tep_ram.sv =====
// ============================================================================
// tep_ram: generic single-port RAM
// One write or read address per cycle, registered read data (read-first).
// ============================================================================
module tep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/timed_event_player_top.sv =====
// ============================================================================
// timed_event_player_top: delta-time event sequencer
// Plays a table of frames (duration word plus value words) against a tick
// driven play time, with trigger seek and end-of-table detection.
// ============================================================================
// Usage:
//   Item channel (item_valid / item_stall): action 1 writes one table word
//   and gives no result beat. Action 0 is a tick: it gives exactly one result
//   beat on the result channel (result_valid/result_stall).
//   Config channel (cfg_valid / cfg_ready): frames_in_use (index 0) and
//   tick_duration (index 1); always ready, write only while the block is idle.
// Sequencing:
//   A plain tick goes S_START, then S_ADV and S_ADV_CMP unless ended, S_ADV_ADD
//   on a frame step, S_OUT, one S_VRD/S_VCAP pair per value word when values
//   are shown, then S_RESULT. One shared 49-bit add/subtract unit does one
//   time add or compare per cycle. A seek walks the table through the duration
//   RAM port, in S_FWD_CHK and S_FWD_ADD per frame forward and S_BACK_RD, S_BACK
//   and S_BACK_CMP per frame backward.
//   item_stall is high from acceptance of a tick until its result is staged.
// Reset:
//   Play time, end time and frame index clear; the first tick reloads the end
//   time from frame 0. Table RAMs are not cleared and must be written first.
// Stall:
//   A staged result holds while result_stall is high; the next item is still
//   accepted and worked on, and waits only to stage its own result.
// ============================================================================
module timed_event_player_top #(
    parameter int FRAMES     = tep_pkg::FRAMES_DEF,
    parameter int NUM_VALUES = tep_pkg::NUM_VALUES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tep_pkg::DATA_W-1:0]         cfg_data,
    // Item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               action,
    input  logic signed [tep_pkg::RATE_W-1:0]  rate,
    input  logic                               trigger,
    input  logic [tep_pkg::DATA_W-1:0]         seek_time,
    input  logic [tep_pkg::FRAME_W-1:0]        entry_frame,
    input  logic [tep_pkg::CHAN_W-1:0]         entry_channel,
    input  logic [tep_pkg::DATA_W-1:0]         entry_data,
    // Result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [tep_pkg::DATA_W-1:0]         value_0,
    output logic [tep_pkg::DATA_W-1:0]         value_1,
    output logic [tep_pkg::DATA_W-1:0]         value_2,
    output logic [tep_pkg::DATA_W-1:0]         value_3,
    output logic [tep_pkg::FRAME_W-1:0]        frame_now,
    output logic                               finished,
    output logic                               finish_pulse
);

    import tep_pkg::*;

    localparam int IW     = $clog2(FRAMES);
    localparam int UW     = $clog2(FRAMES + 1);
    localparam int VDEPTH = FRAMES * NUM_VALUES;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int TW1    = TIME_W + 1;
    localparam int NOUT   = (NUM_VALUES < OUT_VALUES) ? NUM_VALUES : OUT_VALUES;
    localparam int KW     = $clog2(OUT_VALUES);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00_0000_0000_0001,
        S_START    = 14'b00_0000_0000_0010,
        S_BACK_RD  = 14'b00_0000_0000_0100,
        S_BACK     = 14'b00_0000_0000_1000,
        S_BACK_CMP = 14'b00_0000_0001_0000,
        S_FWD_CHK  = 14'b00_0000_0010_0000,
        S_FWD_ADD  = 14'b00_0000_0100_0000,
        S_ADV      = 14'b00_0000_1000_0000,
        S_ADV_CMP  = 14'b00_0001_0000_0000,
        S_ADV_ADD  = 14'b00_0010_0000_0000,
        S_OUT      = 14'b00_0100_0000_0000,
        S_VRD      = 14'b00_1000_0000_0000,
        S_VCAP     = 14'b01_0000_0000_0000,
        S_RESULT   = 14'b10_0000_0000_0000
    } state_t;

    // Control state
    state_t                    state_reg, state_next;
    logic signed [TIME_W-1:0]  play_reg, play_next;
    logic signed [TIME_W-1:0]  end_reg, end_next;
    logic [IW-1:0]             idx_reg, idx_next;
    logic                      ended_reg, ended_next;
    logic                      last_trig_reg, last_trig_next;
    logic                      needs_init_reg, needs_init_next;
    logic [FIU_W-1:0]          frames_in_use_reg, frames_in_use_next;
    logic [DATA_W-1:0]         tick_dur_reg, tick_dur_next;
    logic                      res_valid_reg, res_valid_next;

    // Working payload
    logic signed [TIME_W-1:0]  tmp_reg, tmp_next;
    logic signed [RATE_W-1:0]  rate_reg, rate_next;
    logic [DATA_W-1:0]         seek_reg, seek_next;
    logic                      trig_rise_reg, trig_rise_next;
    logic                      silent_reg, silent_next;
    logic                      pulse_reg, pulse_next;
    logic signed [TIME_W-1:0]  prod_reg, prod_next;
    logic [KW-1:0]             k_reg, k_next;
    logic [DATA_W-1:0]         val_reg [OUT_VALUES];
    logic [DATA_W-1:0]         val_next [OUT_VALUES];

    // Result staging
    logic [DATA_W-1:0]         res_val_reg [OUT_VALUES];
    logic [DATA_W-1:0]         res_val_next [OUT_VALUES];
    logic [FRAME_W-1:0]        res_frame_reg, res_frame_next;
    logic                      res_fin_reg, res_fin_next;
    logic                      res_pulse_reg, res_pulse_next;

    // Shared add/subtract unit
    logic signed [TIME_W:0]    alu_a, alu_b, alu_res;
    logic                      alu_sub;
    logic                      alu_neg, alu_gt;

    // RAM ports
    logic                      dur_we, val_we;
    logic [IW-1:0]             dur_addr;
    logic [VAW-1:0]            val_addr;
    logic [DATA_W-1:0]         dur_q, val_q;

    logic signed [TIME_W-1:0]  prod_mult;
    logic signed [TIME_W-1:0]  first_end, end_eff;
    logic [UW-1:0]             used, idx_inc;
    logic                      item_accept, frame_ok, ch_val_ok;

    assign item_accept = item_valid && !item_stall;
    assign item_stall  = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;

    // Write range checks
    assign frame_ok  = 32'(entry_frame) < FRAMES;
    assign ch_val_ok = (entry_channel != CH_DURATION) && (32'(entry_channel) <= NUM_VALUES);

    // Frames in use, clamped to 1..FRAMES
    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            used = UW'(1);
        end
        else if (32'(frames_in_use_reg) > FRAMES)
        begin
            used = UW'(FRAMES);
        end
        else
        begin
            used = UW'(frames_in_use_reg);
        end
    end

    assign idx_inc = UW'(idx_reg) + UW'(1);

    // Tick increment product (33 x 16 bit)
    assign prod_mult = $signed({1'b0, tick_dur_reg}) * rate_reg;

    // Shared add/subtract unit
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg = alu_res[TIME_W];
    assign alu_gt  = !alu_res[TIME_W] && (alu_res != '0);

    // End time of frame 0, zero duration read as the long default
    assign first_end = (dur_q == '0) ? LONG_FIRST : TIME_W'(dur_q);
    assign end_eff   = needs_init_reg ? first_end : end_reg;

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        play_next          = play_reg;
        end_next           = end_reg;
        idx_next           = idx_reg;
        ended_next         = ended_reg;
        last_trig_next     = last_trig_reg;
        needs_init_next    = needs_init_reg;
        frames_in_use_next = frames_in_use_reg;
        tick_dur_next      = tick_dur_reg;
        res_valid_next     = res_valid_reg;
        tmp_next           = tmp_reg;
        rate_next          = rate_reg;
        seek_next          = seek_reg;
        trig_rise_next     = trig_rise_reg;
        silent_next        = silent_reg;
        pulse_next         = pulse_reg;
        prod_next          = prod_reg;
        k_next             = k_reg;
        val_next           = val_reg;
        res_val_next       = res_val_reg;
        res_frame_next     = res_frame_reg;
        res_fin_next       = res_fin_reg;
        res_pulse_next     = res_pulse_reg;
        alu_a              = '0;
        alu_b              = '0;
        alu_sub            = 1'b0;
        dur_we             = 1'b0;
        val_we             = 1'b0;
        dur_addr           = '0;
        val_addr           = '0;

        // Configuration writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAMES_IN_USE: frames_in_use_next = cfg_data[FIU_W-1:0];
                REG_TICK_DURATION: tick_dur_next      = cfg_data;
                default: ;
            endcase
        end

        // Result beat taken
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    if (action == ACT_WRITE)
                    begin
                        dur_we          = frame_ok && (entry_channel == CH_DURATION);
                        val_we          = frame_ok && ch_val_ok;
                        dur_addr        = IW'(entry_frame);
                        val_addr        = VAW'(32'(entry_frame) * NUM_VALUES
                                               + 32'(entry_channel) - 32'd1);
                        needs_init_next = 1'b1;
                    end
                    else
                    begin
                        // dur_addr stays at frame 0 for the start state
                        rate_next      = rate;
                        seek_next      = seek_time;
                        trig_rise_next = trigger && !last_trig_reg;
                        last_trig_next = trigger;
                        state_next     = S_START;
                    end
                end
            end

            S_START:
            begin
                silent_next     = 1'b0;
                pulse_next      = 1'b0;
                needs_init_next = 1'b0;
                end_next        = end_eff;
                prod_next       = prod_mult;
                alu_a           = TW1'(end_eff);
                alu_b           = TW1'(seek_reg);
                alu_sub         = 1'b1;
                if (trig_rise_reg)
                begin
                    ended_next = 1'b0;
                    play_next  = TIME_W'(seek_reg);
                    if (seek_reg == '0)
                    begin
                        end_next   = first_end;
                        idx_next   = '0;
                        state_next = S_OUT;
                    end
                    else if (alu_gt)
                    begin
                        state_next = S_BACK_RD;
                    end
                    else
                    begin
                        state_next = S_FWD_CHK;
                    end
                end
                else if (!ended_reg)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            // Backward walk: fetch the current frame duration
            S_BACK_RD:
            begin
                dur_addr = idx_reg;
                if (idx_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_BACK;
                end
            end

            S_BACK:
            begin
                alu_a      = TW1'(end_reg);
                alu_b      = TW1'(dur_q);
                alu_sub    = 1'b1;
                tmp_next   = alu_res[TIME_W-1:0];
                state_next = S_BACK_CMP;
            end

            // Step back while the previous end time is still past the target
            S_BACK_CMP:
            begin
                alu_a   = TW1'(tmp_reg);
                alu_b   = TW1'(seek_reg);
                alu_sub = 1'b1;
                if (alu_gt)
                begin
                    end_next   = tmp_reg;
                    idx_next   = idx_reg - IW'(1);
                    state_next = S_BACK_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            // Forward walk while the end time is below the target
            S_FWD_CHK:
            begin
                alu_a    = TW1'(end_reg);
                alu_b    = TW1'(seek_reg);
                alu_sub  = 1'b1;
                dur_addr = IW'(idx_inc);
                if (alu_neg)
                begin
                    if (idx_inc >= used)
                    begin
                        ended_next = 1'b1;
                        pulse_next = 1'b1;
                        play_next  = end_reg;
                        idx_next   = IW'(used - UW'(1));
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = IW'(idx_inc);
                        state_next = S_FWD_ADD;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_FWD_ADD:
            begin
                alu_a      = TW1'(end_reg);
                alu_b      = TW1'(dur_q);
                end_next   = sat_time(alu_res);
                state_next = S_FWD_CHK;
            end

            // Advance play time by the tick increment
            S_ADV:
            begin
                alu_a      = TW1'(play_reg);
                alu_b      = TW1'(prod_reg >>> RATE_FRAC);
                play_next  = sat_time(alu_res);
                state_next = S_ADV_CMP;
            end

            S_ADV_CMP:
            begin
                alu_a    = TW1'(play_reg);
                alu_b    = TW1'(end_reg);
                alu_sub  = 1'b1;
                dur_addr = IW'(idx_inc);
                if (!alu_neg)
                begin
                    if (idx_inc < used)
                    begin
                        idx_next    = IW'(idx_inc);
                        silent_next = 1'b1;
                        state_next  = S_ADV_ADD;
                    end
                    else
                    begin
                        ended_next = 1'b1;
                        pulse_next = 1'b1;
                        play_next  = end_reg;
                        idx_next   = IW'(used - UW'(1));
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_ADV_ADD:
            begin
                alu_a      = TW1'(end_reg);
                alu_b      = TW1'(dur_q);
                end_next   = sat_time(alu_res);
                state_next = S_OUT;
            end

            // Decide whether value words are shown
            S_OUT:
            begin
                for (int i = 0; i < OUT_VALUES; i++)
                begin
                    val_next[i] = '0;
                end
                k_next = '0;
                if ((rate_reg > 16'sd0) && !silent_reg && !ended_reg)
                begin
                    state_next = S_VRD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_VRD:
            begin
                val_addr   = VAW'(32'(idx_reg) * NUM_VALUES + 32'(k_reg));
                state_next = S_VCAP;
            end

            S_VCAP:
            begin
                val_next[k_reg] = val_q;
                if (k_reg == KW'(NOUT - 1))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_VRD;
                end
            end

            // Stage the result once the output register is free
            S_RESULT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_val_next   = val_reg;
                    res_frame_next = FRAME_W'(idx_reg);
                    res_fin_next   = ended_reg;
                    res_pulse_next = pulse_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            play_reg          <= '0;
            end_reg           <= '0;
            idx_reg           <= '0;
            ended_reg         <= 1'b0;
            last_trig_reg     <= 1'b0;
            needs_init_reg    <= 1'b1;
            frames_in_use_reg <= FRAMES_IN_USE_RST;
            tick_dur_reg      <= TICK_DURATION_RST;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            play_reg          <= play_next;
            end_reg           <= end_next;
            idx_reg           <= idx_next;
            ended_reg         <= ended_next;
            last_trig_reg     <= last_trig_next;
            needs_init_reg    <= needs_init_next;
            frames_in_use_reg <= frames_in_use_next;
            tick_dur_reg      <= tick_dur_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tmp_reg       <= tmp_next;
        rate_reg      <= rate_next;
        seek_reg      <= seek_next;
        trig_rise_reg <= trig_rise_next;
        silent_reg    <= silent_next;
        pulse_reg     <= pulse_next;
        prod_reg      <= prod_next;
        k_reg         <= k_next;
        val_reg       <= val_next;
        res_val_reg   <= res_val_next;
        res_frame_reg <= res_frame_next;
        res_fin_reg   <= res_fin_next;
        res_pulse_reg <= res_pulse_next;
    end

    // Table memories
    tep_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FRAMES)
    ) u_dur_ram (
        .clk   (clk),
        .we    (dur_we),
        .addr  (dur_addr),
        .wdata (entry_data),
        .rdata (dur_q)
    );

    tep_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VDEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .addr  (val_addr),
        .wdata (entry_data),
        .rdata (val_q)
    );

    // Outputs
    assign result_valid = res_valid_reg;
    assign value_0      = res_val_reg[0];
    assign value_1      = res_val_reg[1];
    assign value_2      = res_val_reg[2];
    assign value_3      = res_val_reg[3];
    assign frame_now    = res_frame_reg;
    assign finished     = res_fin_reg;
    assign finish_pulse = res_pulse_reg;

    // A new result beat only comes out of the staging state
    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_RESULT))
        else $error("result beat raised outside staging");

    // A finish pulse always comes with the finished flag
    a_pulse_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && finish_pulse) |-> finished)
        else $error("finish pulse without finished flag");

    // Value words 0 and 3 are blank once playback has ended
    a_ended_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && finished) |-> (value_0 == '0 && value_3 == '0))
        else $error("value words shown after the end");

    // An accepted tick always starts the sequencer
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (action == ACT_TICK)) |=> (state_reg == S_START))
        else $error("tick accepted without starting");

endmodule
